// ===== hdl/bounded_ordered_list_engine_top_defines.svh =====
// Assertion macros used by the list engine top module.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BOLE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("list engine check failed");

// Check a property on every clock edge, reset included.
`define BOLE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("list engine check failed");

`endif

// ===== hdl/bole_pkg.sv =====
`default_nettype none

package bole_pkg;

	// Default list capacity
	localparam int DEPTH_DEF = 16;

	// Fixed field widths
	localparam int VAL_W = 32;
	localparam int POS_W = 4;
	localparam int ENT_W = 5;

	typedef enum logic [1:0] {
		MODE_INS_FRONT = 2'd0,
		MODE_INS_END   = 2'd1,
		MODE_DELETE    = 2'd2,
		MODE_READ      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// What a cell loads on the next edge
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_PREV,
		CELL_NEXT,
		CELL_HEAD
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_READ
	} fsm_t;

endpackage

`default_nettype wire

// ===== hdl/bounded_ordered_list_engine_top.sv =====
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells, head in cell 0.
// Insert and delete act in a single step: on a delete or a front insert the cells load from
// their neighbors at once; an end insert loads the first free cell. One result item follows.
// A read-out rotates the chain one place per cycle while the output slot is free, cell 0 feeding
// one result item per step; after a full turn the list is back in order. The output register
// decouples results; an input is taken only while no read-out runs and the output slot is free.
`default_nettype none

`include "bounded_ordered_list_engine_top_defines.svh"

module bounded_ordered_list_engine_top
	import bole_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       mode,
	input  wire logic [VAL_W-1:0] new_value,
	input  wire logic [POS_W-1:0] position,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [VAL_W-1:0]      item_value,
	output logic                  last_item,
	output logic [1:0]            status,
	output logic [ENT_W-1:0]      entry_count
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	fsm_t             state_q, state_nx;
	logic [CW-1:0]    occ_q, occ_nx;
	logic [CW-1:0]    rd_cnt_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] item_value_q;
	logic             last_item_q;
	status_t          status_q;
	logic [CW-1:0]    count_q;

	logic             out_free;
	logic             in_fire;
	logic             rd_step;
	logic             rd_last;
	mode_t            mode_in;
	logic             full;
	logic             empty;
	logic             del_range;
	logic             ins_ok;
	logic             del_ok;
	logic [CW-1:0]    occ_m1;
	status_t          acc_status;

	logic [VAL_W-1:0] cell_val [DEPTH];
	cell_op_t         cell_op  [DEPTH];

	assign mode_in   = mode_t'(mode);
	assign out_free  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign occ_m1    = occ_q - CW'(1);
	assign del_range = (CMPW'(position) >= CMPW'(occ_q));
	assign ins_ok    = in_fire && (mode_in == MODE_INS_FRONT || mode_in == MODE_INS_END) && !full;
	assign del_ok    = in_fire && (mode_in == MODE_DELETE) && !empty && !del_range;
	assign rd_last   = (rd_cnt_q == CW'(1));

	// Status of an insert, delete or empty read-out
	always_comb begin
		acc_status = ST_OK;
		unique case (mode_in)
			MODE_INS_FRONT, MODE_INS_END: begin
				if (full) acc_status = ST_FULL;
			end
			MODE_DELETE: begin
				if (empty) acc_status = ST_EMPTY;
				else if (del_range) acc_status = ST_RANGE;
			end
			MODE_READ: begin
				if (empty) acc_status = ST_EMPTY;
			end
			default: acc_status = ST_OK;
		endcase
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_fire && mode_in == MODE_READ && !empty) state_nx = FSM_READ;
			end
			FSM_READ: begin
				if (out_free && rd_last) state_nx = FSM_IDLE;
			end
			default: state_nx = FSM_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		rd_step  = 1'b0;
		unique case (state_q)
			FSM_IDLE: in_ready = out_free;
			FSM_READ: rd_step  = out_free;
			default: begin
				in_ready = 1'b0;
				rd_step  = 1'b0;
			end
		endcase
	end

	// Occupancy after the accepted item
	always_comb begin
		occ_nx = occ_q;
		if (ins_ok) occ_nx = occ_q + CW'(1);
		else if (del_ok) occ_nx = occ_m1;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			occ_q       <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			occ_q   <= occ_nx;
			if (in_fire && mode_in == MODE_READ) rd_cnt_q <= occ_q;
			else if (rd_step) rd_cnt_q <= rd_cnt_q - CW'(1);
			if ((in_fire && !(mode_in == MODE_READ && !empty)) || rd_step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (rd_step) begin
			item_value_q <= cell_val[0];
			last_item_q  <= rd_last;
			status_q     <= ST_OK;
			count_q      <= occ_q;
		end else if (in_fire) begin
			item_value_q <= '0;
			last_item_q  <= 1'b1;
			status_q     <= acc_status;
			count_q      <= occ_nx;
		end
	end

	// Cell chain: per-cell load select and storage
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] prev_v;
		logic [VAL_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = new_value;
		end else begin : g_mid_prev
			assign prev_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_v = cell_val[0];
		end else begin : g_mid_next
			assign next_v = cell_val[i+1];
		end

		always_comb begin
			cell_op[i] = CELL_HOLD;
			if (rd_step) begin
				if (CW'(i) == occ_m1) cell_op[i] = CELL_HEAD;
				else if (CW'(i) < occ_m1) cell_op[i] = CELL_NEXT;
			end else if (ins_ok && mode_in == MODE_INS_FRONT) begin
				if (i == 0) cell_op[i] = CELL_LOAD;
				else if (CW'(i) <= occ_q) cell_op[i] = CELL_PREV;
			end else if (ins_ok) begin
				if (CW'(i) == occ_q) cell_op[i] = CELL_LOAD;
			end else if (del_ok) begin
				if (CMPW'(i) >= CMPW'(position) && CW'(i) < occ_m1) cell_op[i] = CELL_NEXT;
			end
		end

		bole_cell u_cell (
			.clk        (clk),
			.op         (cell_op[i]),
			.new_value  (new_value),
			.prev_value (prev_v),
			.next_value (next_v),
			.head_value (cell_val[0]),
			.value      (cell_val[i])
		);
	end

	assign out_valid   = out_valid_q;
	assign item_value  = item_value_q;
	assign last_item   = last_item_q;
	assign status      = status_q;
	assign entry_count = ENT_W'(count_q);

	// Checks
	`BOLE_ASSERT_ALWAYS(a_occ_bound, !arst_n || occ_q <= CW'(DEPTH))
	`BOLE_ASSERT(a_occ_still, !in_fire |=> $stable(occ_q))
	`BOLE_ASSERT(a_read_nonempty, state_q == FSM_READ |-> (occ_q != '0 && rd_cnt_q != '0))
	`BOLE_ASSERT(a_refuse_last, (out_valid_q && status_q != ST_OK) |-> last_item_q)
	`BOLE_ASSERT(a_read_end, (rd_step && rd_last) |=> (state_q == FSM_IDLE && last_item_q))

endmodule

`default_nettype wire

// ===== hdl/bole_cell.sv =====
`default_nettype none

module bole_cell
	import bole_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_op_t         op,
	input  wire logic [VAL_W-1:0] new_value,
	input  wire logic [VAL_W-1:0] prev_value,
	input  wire logic [VAL_W-1:0] next_value,
	input  wire logic [VAL_W-1:0] head_value,
	output logic      [VAL_W-1:0] value
);

	logic [VAL_W-1:0] val_q;

	// Load from the new item or a neighbor, else hold
	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: val_q <= new_value;
			CELL_PREV: val_q <= prev_value;
			CELL_NEXT: val_q <= next_value;
			CELL_HEAD: val_q <= head_value;
			default:   val_q <= val_q;
		endcase
	end

	assign value = val_q;

endmodule

`default_nettype wire
